### design/deq_pkg.sv
package deq_pkg;

   // queue geometry
   localparam int DEPTH     = 16;
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int SUM_W     = CNT_W + 1;
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int RSP_CNT_W = 5;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // request command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_VIEW       = 3'd4,
      CMD_COUNT      = 3'd5
   } cmd_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic       view_first;
      logic       view_next;
      logic       emit;
      logic       emit_view;
      logic       emit_last;
      status_type emit_status;
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic single;
      logic view_done;
   } dp_stat_type;

   // ring index plus offset, offset never above DEPTH
   function automatic idx_type wrap_add(idx_type base, cnt_type off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return IDX_W'(sum);
   endfunction

endpackage

### design/deq_ram.sv
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/deq_ctrl.sv
module deq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [deq_pkg::CMD_W-1:0]   command,
   input  deq_pkg::dp_stat_type        stat,
   output deq_pkg::ctrl_cmd_type       cmd,
   output logic                        busy
);

   import deq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_VIEW = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // decode requests and sequence view runs
   always_comb begin
      cmd         = '0;
      cmd.emit_status = STAT_OK;
      state_in    = state_ff;
      busy        = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               unique case (cmd_type'(command))
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     if (stat.full) begin
                        cmd.emit_status = STAT_FULL;
                     end else begin
                        cmd.push_front = (cmd_type'(command) == CMD_PUSH_FRONT);
                        cmd.push_back  = (cmd_type'(command) == CMD_PUSH_BACK);
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (stat.empty) begin
                        cmd.emit_status = STAT_EMPTY;
                     end else begin
                        cmd.pop_front = (cmd_type'(command) == CMD_POP_FRONT);
                        cmd.pop_back  = (cmd_type'(command) == CMD_POP_BACK);
                     end
                  end
                  CMD_VIEW: begin
                     if (stat.empty) begin
                        cmd.emit_status = STAT_EMPTY;
                     end else begin
                        cmd.view_first = 1'b1;
                        cmd.emit_view  = 1'b1;
                        cmd.emit_last  = stat.single;
                        if (!stat.single) begin
                           state_in = S_VIEW;
                        end
                     end
                  end
                  default: begin
                     // count and unused codes report the count
                     cmd.emit_status = STAT_OK;
                  end
               endcase
            end
         end
         S_VIEW: begin
            cmd.view_next = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_view = 1'b1;
            cmd.emit_last = stat.view_done;
            if (stat.view_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/deq_datapath.sv
module deq_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  deq_pkg::ctrl_cmd_type            cmd,
   input  logic signed [deq_pkg::DATA_W-1:0] push_value,
   output deq_pkg::dp_stat_type             stat,
   output logic                             rsp_valid,
   output logic [deq_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [deq_pkg::DATA_W-1:0] rsp_element_value,
   output logic [deq_pkg::RSP_CNT_W-1:0]    rsp_element_count,
   output logic                             rsp_last_of_run
);

   import deq_pkg::*;

   idx_type    front_ff, front_in;
   cnt_type    count_ff, count_in;
   idx_type    pos_ff, pos_in;
   logic       valid_ff;
   status_type status_ff;
   logic       last_ff;
   logic       view_ff;

   logic              wr_en;
   idx_type           wr_addr;
   logic              rd_en;
   idx_type           rd_addr;
   logic [DATA_W-1:0] rd_data;

   // status toward the controller
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff >= CNT_W'(DEPTH));
   assign stat.single    = (count_ff == CNT_W'(1));
   assign stat.view_done = ((CNT_W'(pos_ff) + CNT_W'(1)) == count_ff);

   // ring pointer updates and memory addressing
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      wr_en    = 1'b0;
      wr_addr  = wrap_add(front_ff, count_ff);
      rd_en    = 1'b0;
      rd_addr  = front_ff;
      if (cmd.push_front) begin
         front_in = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
         wr_en    = 1'b1;
         wr_addr  = front_in;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.push_back) begin
         wr_en    = 1'b1;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.pop_front) begin
         front_in = wrap_add(front_ff, CNT_W'(1));
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.pop_back) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.view_first) begin
         rd_en  = 1'b1;
         pos_in = IDX_W'(1);
      end
      if (cmd.view_next) begin
         rd_en   = 1'b1;
         rd_addr = wrap_add(front_ff, CNT_W'(pos_ff));
         pos_in  = pos_ff + IDX_W'(1);
      end
   end

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         valid_ff <= cmd.emit;
      end
   end

   // response payload registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      status_ff <= cmd.emit_status;
      last_ff   <= cmd.emit_last;
      view_ff   <= cmd.emit_view;
   end

   // response ports, count is the value after the request
   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_element_value = view_ff ? rd_data : '0;
   assign rsp_element_count = RSP_CNT_W'(count_ff);
   assign rsp_last_of_run   = last_ff;

endmodule

### design/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values in a 16-entry ring store.
// Request channel: a request (req_command, req_push_value) is taken at a rising
// edge with start high and busy low. Commands: push front, push back, pop
// front, pop back, view, count.
// Response channel: each response sits on the rsp_ ports for exactly one
// cycle with rsp_valid high; rsp_last_of_run marks the final response of a
// request. There is no backpressure: the receiver must take every response.
// Latency: the first response of any request appears in the cycle after it is
// taken. Push, pop and count give one response and leave busy low, so a new
// request can follow every cycle. View on a queue holding N elements streams
// N responses on consecutive cycles, one store read per cycle through the
// registered read port of the ring memory; busy stays high while the later ones are read.
// A push to a full queue is dropped with status full; a pop or view on an
// empty queue gives one response with status empty.
// Reset (synchronous, active high) empties the queue and clears the front
// pointer; store contents are not cleared and no clearing pass is needed.
module double_ended_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [deq_pkg::CMD_W-1:0]         req_command,
   input  logic signed [deq_pkg::DATA_W-1:0] req_push_value,
   output logic                              rsp_valid,
   output logic [deq_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [deq_pkg::DATA_W-1:0] rsp_element_value,
   output logic [deq_pkg::RSP_CNT_W-1:0]     rsp_element_count,
   output logic                              rsp_last_of_run
);

   import deq_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequencer
   deq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .stat    (stat),
      .cmd     (cmd),
      .busy    (busy)
   );

   // ring store and pointers
   deq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .push_value        (req_push_value),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_element_value (rsp_element_value),
      .rsp_element_count (rsp_element_count),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

### tb/deq_reply_checker.sv
module deq_reply_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [deq_pkg::CMD_W-1:0]         req_command,
   input  logic signed [deq_pkg::DATA_W-1:0] req_push_value,
   input  logic                              rsp_valid,
   input  logic [deq_pkg::STATUS_W-1:0]      rsp_status,
   input  logic signed [deq_pkg::DATA_W-1:0] rsp_element_value,
   input  logic [deq_pkg::RSP_CNT_W-1:0]     rsp_element_count,
   input  logic                              rsp_last_of_run,
   output int                                fail_count,
   output int                                due_count
);

   import deq_pkg::*;

   // one response as the queue should give it
   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] value;
      logic [RSP_CNT_W-1:0]     count;
      logic                     last;
   } deq_reply_type;

   // shadow ring store, front pointer and fill level
   logic signed [DATA_W-1:0] ring [DEPTH];
   int unsigned              head;
   int unsigned              held;

   deq_reply_type replies_due[$];
   int            mismatches = 0;

   // print one line per wrong field and count it
   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] seen,
                                  input logic [DATA_W-1:0] wanted);
      mismatches++;
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, seen, wanted);
   endtask

   // response built from the fill level after the request
   function automatic deq_reply_type make_reply(input status_type st,
                                                input logic signed [DATA_W-1:0] value,
                                                input logic last);
      deq_reply_type r;
      r.status = st;
      r.value  = value;
      r.count  = RSP_CNT_W'(held);
      r.last   = last;
      return r;
   endfunction

   // apply one request to the shadow queue and list its responses
   task automatic model_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [DATA_W-1:0] value);
      int unsigned k;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (held >= DEPTH) begin
               replies_due.push_back(make_reply(STAT_FULL, '0, 1'b1));
            end else begin
               if (cmd == CMD_PUSH_FRONT) begin
                  head       = (head + DEPTH - 1) % DEPTH;
                  ring[head] = value;
               end else begin
                  ring[(head + held) % DEPTH] = value;
               end
               held++;
               replies_due.push_back(make_reply(STAT_OK, '0, 1'b1));
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (held == 0) begin
               replies_due.push_back(make_reply(STAT_EMPTY, '0, 1'b1));
            end else begin
               if (cmd == CMD_POP_FRONT) begin
                  head = (head + 1) % DEPTH;
               end
               held--;
               replies_due.push_back(make_reply(STAT_OK, '0, 1'b1));
            end
         end
         CMD_VIEW: begin
            if (held == 0) begin
               replies_due.push_back(make_reply(STAT_EMPTY, '0, 1'b1));
            end else begin
               for (k = 0; k < held; k++) begin
                  replies_due.push_back(make_reply(STAT_OK, ring[(head + k) % DEPTH],
                                                   k + 1 == held));
               end
            end
         end
         // count and the unused codes leave the queue alone
         default: begin
            replies_due.push_back(make_reply(STAT_OK, '0, 1'b1));
         end
      endcase
   endtask

   // responses from earlier requests first, then the request taken at this edge
   always @(posedge clock) begin
      deq_reply_type want;
      if (reset) begin
         head = 0;
         held = 0;
         replies_due.delete();
      end else begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               report_mismatch("response with none due", rsp_element_value, '0);
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", DATA_W'(rsp_status), DATA_W'(want.status));
               if (rsp_element_value !== want.value)
                  report_mismatch("element_value", rsp_element_value, want.value);
               if (rsp_element_count !== want.count)
                  report_mismatch("element_count", DATA_W'(rsp_element_count),
                                  DATA_W'(want.count));
               if (rsp_last_of_run !== want.last)
                  report_mismatch("last_of_run", DATA_W'(rsp_last_of_run),
                                  DATA_W'(want.last));
            end
         end
         if (start && !busy) begin
            model_request(req_command, req_push_value);
         end
      end
      due_count  <= replies_due.size();
      fail_count <= mismatches;
   end

endmodule

### tb/double_ended_queue_tb.sv
module double_ended_queue_tb;
   import deq_pkg::*;

   localparam int RANDOM_REQUESTS = 320;
   localparam int DRAIN_CYCLES    = DEPTH + 4;
   localparam int WATCHDOG_LIMIT  = 2000;

   // command codes the block does not define
   localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

   // traffic mixes for the random part
   localparam int FILL_MODE  = 0;
   localparam int DRAIN_MODE = 1;
   localparam int MIXED_MODE = 2;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [CMD_W-1:0]         req_command;
   logic signed [DATA_W-1:0] req_push_value;
   logic                     rsp_valid;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_element_value;
   logic [RSP_CNT_W-1:0]     rsp_element_count;
   logic                     rsp_last_of_run;
   int                       fail_count;
   int                       due_count;
   int                       idle_cycles = 0;

   double_ended_queue i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_element_value (rsp_element_value),
      .rsp_element_count (rsp_element_count),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   deq_reply_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_element_value (rsp_element_value),
      .rsp_element_count (rsp_element_count),
      .rsp_last_of_run   (rsp_last_of_run),
      .fail_count        (fail_count),
      .due_count         (due_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hold a request until the block takes it
   task automatic issue_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [DATA_W-1:0] value);
      start          <= 1'b1;
      req_command    <= cmd;
      req_push_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // mostly back to back, some short gaps, a few long ones
   task automatic idle_gap();
      int r;
      int len;
      r   = $urandom_range(0, 99);
      len = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (len > 0) begin
         start <= 1'b0;
         repeat (len) @(posedge clock);
      end
   endtask

   // extremes often, otherwise any value
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // push share depends on the mix so the queue swings between empty and full
   function automatic logic [CMD_W-1:0] pick_command(input int mode);
      int push_share;
      int r;
      push_share = (mode == FILL_MODE) ? 65 : (mode == DRAIN_MODE) ? 25 : 45;
      r = $urandom_range(0, 99);
      if (r < push_share) return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      if (r < 85) return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      if (r < 93) return CMD_VIEW;
      if (r < 97) return CMD_COUNT;
      return $urandom_range(0, 1) ? CMD_UNUSED_B : CMD_UNUSED_A;
   endfunction

   // stimulus
   initial begin
      logic signed [DATA_W-1:0] v;
      int                       mode;
      bit                       calm;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_command    <= CMD_COUNT;
      req_push_value <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty queue cases
      issue_request(CMD_VIEW, pick_value());
      issue_request(CMD_POP_FRONT, '0);
      issue_request(CMD_POP_BACK, '1);
      // fill from both ends, wrapping the front pointer
      for (int k = 0; k < DEPTH; k++) begin
         case (k)
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = '0;
            3: v = '1;
            default: v = $urandom;
         endcase
         issue_request(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, v);
         idle_gap();
      end
      // full queue: both pushes dropped, then a full view, both pops, count and an unused code
      issue_request(CMD_PUSH_FRONT, pick_value());
      issue_request(CMD_PUSH_BACK, pick_value());
      issue_request(CMD_VIEW, pick_value());
      issue_request(CMD_POP_FRONT, pick_value());
      issue_request(CMD_POP_BACK, pick_value());
      issue_request(CMD_COUNT, pick_value());
      issue_request(CMD_UNUSED_B, pick_value());
      idle_gap();

      // random traffic in stretches of one mix each
      mode = MIXED_MODE;
      calm = 1'b0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 40 == 0) begin
            mode = $urandom_range(FILL_MODE, MIXED_MODE);
            calm = ($urandom_range(0, 3) == 0);
         end
         // hold off once until every response has come
         if (n == RANDOM_REQUESTS / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (due_count != 0);
         end
         issue_request(pick_command(mode), pick_value());
         if (!calm) idle_gap();
      end

      // drain and verdict
      start <= 1'b0;
      do @(posedge clock); while (due_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && due_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog on cycles with no request taken and no response
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
